### rtl/dslr_pkg.sv
// Shared definitions for the double-step line rasterizer.
// Holds default widths and the line mode flags. No dependencies.
`default_nettype none

package dslr_pkg;

  localparam int unsigned DSLR_COORD_BITS = 12;
  localparam int unsigned DSLR_COLOR_BITS = 24;

  // Opcode of an input item.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Per-line mode bits, fixed at start.
  typedef struct packed {
    logic second;  // 4*minor >= 2*major branch
    logic yneg;    // y steps down from the first endpoint
    logic xneg;    // x steps down from the first endpoint
    logic ymaj;    // y is the major axis
  } mode_t;

endpackage

`default_nettype wire

### rtl/dslr_setup.sv
// Line setup: spans, major axis, step counts and decision terms for a start item.
// Depends on dslr_pkg.
`default_nettype none

module dslr_setup #(
  parameter int unsigned COORD_BITS = dslr_pkg::DSLR_COORD_BITS
) (
  input  wire logic [COORD_BITS-1:0]        x_start,
  input  wire logic [COORD_BITS-1:0]        y_start,
  input  wire logic [COORD_BITS-1:0]        x_end,
  input  wire logic [COORD_BITS-1:0]        y_end,
  output dslr_pkg::mode_t                   mode,
  output logic [COORD_BITS-3:0]             steps,
  output logic [1:0]                        extra,
  output logic signed [COORD_BITS+1:0]      thr,
  output logic signed [COORD_BITS+2:0]      inc1,
  output logic signed [COORD_BITS+2:0]      inc2,
  output logic signed [COORD_BITS+4:0]      dec,
  output logic                              active
);
  import dslr_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0]   dx, dy, mj, mn, mj_m1;
  logic            xneg, yneg, ymaj, second;
  logic [CB+2:0]   mn4, mj2;
  logic [CB+1:0]   mn_w, mj_w;

  always_comb begin
    xneg  = x_end < x_start;
    yneg  = y_end < y_start;
    dx    = xneg ? (x_start - x_end) : (x_end - x_start);
    dy    = yneg ? (y_start - y_end) : (y_end - y_start);
    ymaj  = !(dx > dy);
    mj    = ymaj ? dy : dx;
    mn    = ymaj ? dx : dy;
    mj_m1 = (mj == '0) ? '0 : (mj - {{(CB-1){1'b0}}, 1'b1});
    steps = mj_m1[CB-1:2];
    extra = mj_m1[1:0];

    mn4    = {3'b000, mn} << 2;
    mj2    = {3'b000, mj} << 1;
    inc2   = $signed(mn4 - mj2);
    second = !inc2[CB+2];

    mn_w = {2'b00, mn};
    mj_w = {2'b00, mj};
    thr  = second ? $signed((mn_w - mj_w) << 1) : $signed(mn_w << 1);
    inc1 = $signed({thr[CB+1], thr} << 1);
    dec  = second ? ($signed({{2{inc1[CB+2]}}, inc1}) + $signed({5'b00000, mj}))
                  : ($signed({{2{inc1[CB+2]}}, inc1}) - $signed({5'b00000, mj}));

    mode.second = second;
    mode.yneg   = yneg;
    mode.xneg   = xneg;
    mode.ymaj   = ymaj;
    active      = (steps != '0) || (extra != 2'b00);
  end

endmodule

`default_nettype wire

### rtl/dslr_advance.sv
// Advance step: one double step from both ends, or the closing extra pixels.
// Depends on dslr_pkg.
`default_nettype none

module dslr_advance #(
  parameter int unsigned COORD_BITS = dslr_pkg::DSLR_COORD_BITS
) (
  input  wire dslr_pkg::mode_t              mode,
  input  wire logic                         active,
  input  wire logic [COORD_BITS-3:0]        steps,
  input  wire logic [1:0]                   extra,
  input  wire logic signed [COORD_BITS+1:0] thr,
  input  wire logic signed [COORD_BITS+2:0] inc1,
  input  wire logic signed [COORD_BITS+2:0] inc2,
  input  wire logic signed [COORD_BITS+4:0] dec,
  input  wire logic [COORD_BITS-1:0]        front_x,
  input  wire logic [COORD_BITS-1:0]        front_y,
  input  wire logic [COORD_BITS-1:0]        back_x,
  input  wire logic [COORD_BITS-1:0]        back_y,
  output logic [2:0]                        count,
  output logic [COORD_BITS-1:0]             xa,
  output logic [COORD_BITS-1:0]             ya,
  output logic [COORD_BITS-1:0]             xb,
  output logic [COORD_BITS-1:0]             yb,
  output logic [COORD_BITS-1:0]             xc,
  output logic [COORD_BITS-1:0]             yc,
  output logic [COORD_BITS-1:0]             xd,
  output logic [COORD_BITS-1:0]             yd,
  output logic                              last,
  output logic [COORD_BITS-1:0]             front_x_next,
  output logic [COORD_BITS-1:0]             front_y_next,
  output logic [COORD_BITS-1:0]             back_x_next,
  output logic [COORD_BITS-1:0]             back_y_next,
  output logic signed [COORD_BITS+4:0]      dec_next,
  output logic [COORD_BITS-3:0]             steps_next,
  output logic                              active_next
);
  import dslr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 5;
  localparam int unsigned SW = COORD_BITS - 2;

  typedef enum logic [1:0] {
    KIND_AXIAL   = 2'd0,
    KIND_AX_DIAG = 2'd1,
    KIND_DIAG_AX = 2'd2,
    KIND_DIAG2   = 2'd3
  } kind_t;

  // Walk one coordinate by n unit steps, wrapping.
  function automatic logic [CB-1:0] walk(input logic [CB-1:0] v, input logic down,
                                          input logic [1:0] n);
    logic [CB-1:0] nn;
    begin
      nn   = {{(CB-2){1'b0}}, n};
      walk = down ? (v - nn) : (v + nn);
    end
  endfunction

  // Position of an end after a major and b minor steps; returns {x, y}.
  function automatic logic [2*CB-1:0] pos(input logic [CB-1:0] px, input logic [CB-1:0] py,
                                           input logic xdown, input logic ydown,
                                           input logic ymaj, input logic [1:0] a,
                                           input logic [1:0] b);
    begin
      pos = ymaj ? {walk(px, xdown, b), walk(py, ydown, a)}
                 : {walk(px, xdown, a), walk(py, ydown, b)};
    end
  endfunction

  kind_t                kind;
  logic [1:0]           f1, f2, g2;
  logic                 d1, d2, d3;
  logic signed [DW-1:0] thr_w;
  logic [2*CB-1:0]      pa, pb, pc, pd, ea, eb, ec;
  logic [SW-1:0]        steps_dec;

  always_comb begin
    thr_w = $signed({{(DW-CB-2){thr[CB+1]}}, thr});

    if (!mode.second && dec < 0)          kind = KIND_AXIAL;
    else if (mode.second && dec > 0)      kind = KIND_DIAG2;
    else if (dec < thr_w)                 kind = KIND_AX_DIAG;
    else                                  kind = KIND_DIAG_AX;

    unique case (kind)
      KIND_AXIAL:   begin f1 = 2'd0; f2 = 2'd0; end
      KIND_AX_DIAG: begin f1 = 2'd0; f2 = 2'd1; end
      KIND_DIAG_AX: begin f1 = 2'd1; f2 = 2'd1; end
      KIND_DIAG2:   begin f1 = 2'd1; f2 = 2'd2; end
      default:      begin f1 = 2'd0; f2 = 2'd0; end
    endcase

    // closing pixels: minor moves per extra step
    if (!mode.second && dec < 0) begin
      d1 = 1'b0; d2 = 1'b0; d3 = 1'b0;
    end else if (mode.second && dec > 0) begin
      d1 = 1'b1; d2 = 1'b1; d3 = 1'b1;
    end else if (dec < thr_w) begin
      d1 = 1'b0; d2 = 1'b1; d3 = 1'b0;
    end else begin
      d1 = 1'b1; d2 = 1'b0; d3 = mode.second ? (dec > thr_w) : 1'b1;
    end
    g2 = {1'b0, d1} + {1'b0, d2};

    pa = pos(front_x, front_y, mode.xneg, mode.yneg, mode.ymaj, 2'd1, f1);
    pb = pos(front_x, front_y, mode.xneg, mode.yneg, mode.ymaj, 2'd2, f2);
    pc = pos(back_x, back_y, !mode.xneg, !mode.yneg, mode.ymaj, 2'd1, f1);
    pd = pos(back_x, back_y, !mode.xneg, !mode.yneg, mode.ymaj, 2'd2, f2);
    ea = pos(front_x, front_y, mode.xneg, mode.yneg, mode.ymaj, 2'd1, {1'b0, d1});
    eb = pos(front_x, front_y, mode.xneg, mode.yneg, mode.ymaj, 2'd2, g2);
    ec = pos(back_x, back_y, !mode.xneg, !mode.yneg, mode.ymaj, 2'd1, {1'b0, d3});

    steps_dec = steps - {{(SW-1){1'b0}}, 1'b1};

    // default: no line, nothing moves
    count        = 3'd0;
    xa = '0; ya = '0; xb = '0; yb = '0;
    xc = '0; yc = '0; xd = '0; yd = '0;
    last         = 1'b1;
    front_x_next = front_x;
    front_y_next = front_y;
    back_x_next  = back_x;
    back_y_next  = back_y;
    dec_next     = dec;
    steps_next   = steps;
    active_next  = active;

    if (active && steps != '0) begin
      count        = 3'd4;
      {xa, ya}     = pa;
      {xb, yb}     = pb;
      {xc, yc}     = pc;
      {xd, yd}     = pd;
      {front_x_next, front_y_next} = pb;
      {back_x_next, back_y_next}   = pd;
      dec_next     = dec + ((kind == KIND_AXIAL || kind == KIND_DIAG2)
                            ? $signed({{2{inc1[CB+2]}}, inc1})
                            : $signed({{2{inc2[CB+2]}}, inc2}));
      steps_next   = steps_dec;
      last         = (steps_dec == '0) && (extra == 2'b00);
      active_next  = !last;
    end else if (active) begin
      count = {1'b0, extra};
      if (extra != 2'b00) {xa, ya} = ea;
      if (extra > 2'd1)   {xb, yb} = eb;
      if (extra > 2'd2)   {xc, yc} = ec;
      active_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/double_step_line_rasterizer.sv
// Top level of the symmetric double-step line rasterizer.
// Depends on dslr_pkg, dslr_setup and dslr_advance.
`default_nettype none

// Symmetric double-step line rasterizer. Send a start item (op = 0) with both
// endpoints and a color; its result holds the two endpoint pixels. Then send
// advance items (op = 1): each returns four pixels, two walked in from each
// end. The final advance sets last and returns the one to three middle pixels,
// or the last four walked pixels if no middle pixels are left. A start whose
// result already has last set (zero length or major span of one) needs no
// advance. An advance with no line in progress returns an empty group with
// last set. A start always drops any line in progress. Timing: one item per
// cycle. All work for an item sits between the line state registers and the
// result register; in_stall only rises while out_stall holds a finished result.
module double_step_line_rasterizer #(
  parameter int unsigned COORD_BITS = dslr_pkg::DSLR_COORD_BITS,
  parameter int unsigned COLOR_BITS = dslr_pkg::DSLR_COLOR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  op,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  input  wire logic [COLOR_BITS-1:0] pen_color,
  // pixel group output channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 pixel_count,
  output logic [COORD_BITS-1:0]      xa,
  output logic [COORD_BITS-1:0]      ya,
  output logic [COORD_BITS-1:0]      xb,
  output logic [COORD_BITS-1:0]      yb,
  output logic [COORD_BITS-1:0]      xc,
  output logic [COORD_BITS-1:0]      yc,
  output logic [COORD_BITS-1:0]      xd,
  output logic [COORD_BITS-1:0]      yd,
  output logic [COLOR_BITS-1:0]      pixel_color,
  output logic                       last
);
  import dslr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 5;
  localparam int unsigned SW = COORD_BITS - 2;

  // Line state
  logic [CB-1:0]          front_x, front_y, back_x, back_y;
  logic signed [DW-1:0]   decision;
  logic signed [CB+1:0]   threshold_c;
  logic signed [CB+2:0]   increment_one, increment_two;
  logic [SW-1:0]          steps_left;
  logic [1:0]             extra_pixels;
  mode_t                  mode_flags;
  logic [COLOR_BITS-1:0]  line_color;
  logic                   active;

  // Setup results for a start item
  mode_t                  su_mode;
  logic [SW-1:0]          su_steps;
  logic [1:0]             su_extra;
  logic signed [CB+1:0]   su_thr;
  logic signed [CB+2:0]   su_inc1, su_inc2;
  logic signed [DW-1:0]   su_dec;
  logic                   su_active;

  // Advance results
  logic [2:0]             adv_count;
  logic [CB-1:0]          adv_xa, adv_ya, adv_xb, adv_yb, adv_xc, adv_yc, adv_xd, adv_yd;
  logic                   adv_last;
  logic [CB-1:0]          adv_fx, adv_fy, adv_bx, adv_by;
  logic signed [DW-1:0]   adv_dec;
  logic [SW-1:0]          adv_steps;
  logic                   adv_active;

  logic                   accept;

  dslr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .mode    (su_mode),
    .steps   (su_steps),
    .extra   (su_extra),
    .thr     (su_thr),
    .inc1    (su_inc1),
    .inc2    (su_inc2),
    .dec     (su_dec),
    .active  (su_active)
  );

  dslr_advance #(.COORD_BITS(COORD_BITS)) u_advance (
    .mode         (mode_flags),
    .active       (active),
    .steps        (steps_left),
    .extra        (extra_pixels),
    .thr          (threshold_c),
    .inc1         (increment_one),
    .inc2         (increment_two),
    .dec          (decision),
    .front_x      (front_x),
    .front_y      (front_y),
    .back_x       (back_x),
    .back_y       (back_y),
    .count        (adv_count),
    .xa           (adv_xa),
    .ya           (adv_ya),
    .xb           (adv_xb),
    .yb           (adv_yb),
    .xc           (adv_xc),
    .yc           (adv_yc),
    .xd           (adv_xd),
    .yd           (adv_yd),
    .last         (adv_last),
    .front_x_next (adv_fx),
    .front_y_next (adv_fy),
    .back_x_next  (adv_bx),
    .back_y_next  (adv_by),
    .dec_next     (adv_dec),
    .steps_next   (adv_steps),
    .active_next  (adv_active)
  );

  // The result register is the only buffer: take a new item unless the held
  // result is stalled.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Control and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      active        <= 1'b0;
      front_x       <= '0;
      front_y       <= '0;
      back_x        <= '0;
      back_y        <= '0;
      decision      <= '0;
      threshold_c   <= '0;
      increment_one <= '0;
      increment_two <= '0;
      steps_left    <= '0;
      extra_pixels  <= '0;
      mode_flags    <= '0;
      line_color    <= '0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (accept && op == OP_START) begin
        front_x       <= x_start;
        front_y       <= y_start;
        back_x        <= x_end;
        back_y        <= y_end;
        decision      <= su_dec;
        threshold_c   <= su_thr;
        increment_one <= su_inc1;
        increment_two <= su_inc2;
        steps_left    <= su_steps;
        extra_pixels  <= su_extra;
        mode_flags    <= su_mode;
        line_color    <= pen_color;
        active        <= su_active;
      end else if (accept && op == OP_ADVANCE) begin
        front_x    <= adv_fx;
        front_y    <= adv_fy;
        back_x     <= adv_bx;
        back_y     <= adv_by;
        decision   <= adv_dec;
        steps_left <= adv_steps;
        active     <= adv_active;
      end
    end
  end

  // Result payload, loaded on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      if (op == OP_START) begin
        pixel_count <= 3'd2;
        xa          <= x_start;
        ya          <= y_start;
        xb          <= x_end;
        yb          <= y_end;
        xc          <= '0;
        yc          <= '0;
        xd          <= '0;
        yd          <= '0;
        pixel_color <= pen_color;
        last        <= !su_active;
      end else begin
        pixel_count <= adv_count;
        xa          <= adv_xa;
        ya          <= adv_ya;
        xb          <= adv_xb;
        yb          <= adv_yb;
        xc          <= adv_xc;
        yc          <= adv_yc;
        xd          <= adv_xd;
        yd          <= adv_yd;
        pixel_color <= (adv_count != 3'd0) ? line_color : '0;
        last        <= adv_last;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dslr_checker.sv
// Port-level checks for the double-step line rasterizer, bound to the top level.
// Depends on dslr_pkg and double_step_line_rasterizer.
`default_nettype none

module dslr_checker #(
  parameter int unsigned COORD_BITS = dslr_pkg::DSLR_COORD_BITS,
  parameter int unsigned COLOR_BITS = dslr_pkg::DSLR_COLOR_BITS
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  op,
  input wire logic [COORD_BITS-1:0] x_start,
  input wire logic [COORD_BITS-1:0] y_start,
  input wire logic [COORD_BITS-1:0] x_end,
  input wire logic [COORD_BITS-1:0] y_end,
  input wire logic [COLOR_BITS-1:0] pen_color,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [2:0]            pixel_count,
  input wire logic [COORD_BITS-1:0] xa,
  input wire logic [COORD_BITS-1:0] ya,
  input wire logic [COORD_BITS-1:0] xb,
  input wire logic [COORD_BITS-1:0] yb,
  input wire logic [COORD_BITS-1:0] xc,
  input wire logic [COORD_BITS-1:0] yc,
  input wire logic [COORD_BITS-1:0] xd,
  input wire logic [COORD_BITS-1:0] yd,
  input wire logic [COLOR_BITS-1:0] pixel_color,
  input wire logic                  last
);
  import dslr_pkg::*;

  // A start item comes back next cycle as its two endpoints in its color.
  a_start_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_START |=>
      out_valid && pixel_count == 3'd2 && xa == $past(x_start) && ya == $past(y_start)
      && xb == $past(x_end) && yb == $past(y_end) && pixel_color == $past(pen_color))
    else $error("start item result mismatch");

  // An empty group only ever closes the line, with no color.
  a_empty_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_count == 3'd0 |-> last && pixel_color == '0)
    else $error("empty pixel group without last or with color");

  // Never more than four pixels in a group.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixel_count <= 3'd4)
    else $error("pixel count out of range");

  // The input side is only held off by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_count)
      && $stable(xa) && $stable(ya) && $stable(xb) && $stable(yb)
      && $stable(xc) && $stable(yc) && $stable(xd) && $stable(yd)
      && $stable(pixel_color) && $stable(last))
    else $error("stalled result changed");

endmodule

bind double_step_line_rasterizer dslr_checker #(
  .COORD_BITS(COORD_BITS),
  .COLOR_BITS(COLOR_BITS)
) u_dslr_checker (.*);

`default_nettype wire

### tb/dslr_pixel_checker.sv
// Watches both channels of the double-step line rasterizer, predicts each pixel group.
// Compares it field by field. Depends on dslr_pkg (widths, opcodes, mode_t).
module dslr_pixel_checker #(
  parameter int unsigned CB   = dslr_pkg::DSLR_COORD_BITS,
  parameter int unsigned COLB = dslr_pkg::DSLR_COLOR_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  logic            op,
  input  logic [CB-1:0]   x_start,
  input  logic [CB-1:0]   y_start,
  input  logic [CB-1:0]   x_end,
  input  logic [CB-1:0]   y_end,
  input  logic [COLB-1:0] pen_color,
  input  logic            out_valid,
  input  logic            out_stall,
  input  logic [2:0]      pixel_count,
  input  logic [CB-1:0]   xa,
  input  logic [CB-1:0]   ya,
  input  logic [CB-1:0]   xb,
  input  logic [CB-1:0]   yb,
  input  logic [CB-1:0]   xc,
  input  logic [CB-1:0]   yc,
  input  logic [CB-1:0]   xd,
  input  logic [CB-1:0]   yd,
  input  logic [COLB-1:0] pixel_color,
  input  logic            last,
  output int unsigned     fail_count,
  output int unsigned     pending_groups,
  output int unsigned     groups_checked,
  output int unsigned     pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dslr_pkg::*;

  typedef struct packed {
    logic [2:0]      count;
    logic [CB-1:0]   xa, ya, xb, yb, xc, yc, xd, yd;
    logic [COLB-1:0] color;
    logic            last;
  } pixel_group_t;

  // line walker state
  logic [CB-1:0]   front_x, front_y, back_x, back_y;
  int              decision, thresh, inc_one, inc_two;
  int unsigned     steps_left, extra_left;
  mode_t           mode;
  logic [COLB-1:0] line_color;
  bit              line_active;

  // pixel slots of the group being built
  logic [CB-1:0]   slot_x[4], slot_y[4];
  int              slot_n;

  pixel_group_t    expected_groups[$];
  int unsigned     errors, groups, pixels;

  function automatic logic [CB-1:0] walk(input logic [CB-1:0] v, input bit down);
    return down ? v - 1'b1 : v + 1'b1;
  endfunction

  // front end walks toward the far end, back end walks the other way
  function automatic void step_major(input bit fwd);
    if (mode.ymaj) begin
      if (fwd) front_y = walk(front_y, mode.yneg);
      else     back_y  = walk(back_y, !mode.yneg);
    end else begin
      if (fwd) front_x = walk(front_x, mode.xneg);
      else     back_x  = walk(back_x, !mode.xneg);
    end
  endfunction

  function automatic void step_minor(input bit fwd);
    if (mode.ymaj) begin
      if (fwd) front_x = walk(front_x, mode.xneg);
      else     back_x  = walk(back_x, !mode.xneg);
    end else begin
      if (fwd) front_y = walk(front_y, mode.yneg);
      else     back_y  = walk(back_y, !mode.yneg);
    end
  endfunction

  function automatic void emit(input bit fwd);
    if (slot_n < 4) begin
      slot_x[slot_n] = fwd ? front_x : back_x;
      slot_y[slot_n] = fwd ? front_y : back_y;
      slot_n++;
    end
  endfunction

  // 0: axial,axial  1: axial,diagonal  2: diagonal,axial  3: diagonal,diagonal
  function automatic void walk_pattern(input bit fwd, input int shape);
    if (shape == 2 || shape == 3) step_minor(fwd);
    emit(fwd);
    step_major(fwd);
    if (shape == 1 || shape == 3) step_minor(fwd);
    emit(fwd);
  endfunction

  function automatic void double_step();
    int shape;
    step_major(1'b1);
    step_major(1'b0);
    if (!mode.second) shape = (decision < 0) ? 0 : ((decision < thresh) ? 1 : 2);
    else              shape = (decision > 0) ? 3 : ((decision < thresh) ? 1 : 2);
    walk_pattern(1'b1, shape);
    walk_pattern(1'b0, shape);
    decision += (shape == 0 || shape == 3) ? inc_one : inc_two;
  endfunction

  function automatic void tail_step(input bit fwd, input bit diag);
    step_major(fwd);
    if (diag) step_minor(fwd);
    emit(fwd);
  endfunction

  // middle pixels left after the last double step
  function automatic void finish_middle();
    bit d1, d2, d3;
    if (!mode.second && decision < 0) begin
      d1 = 0; d2 = 0; d3 = 0;
    end else if (mode.second && decision > 0) begin
      d1 = 1; d2 = 1; d3 = 1;
    end else if (decision < thresh) begin
      d1 = 0; d2 = 1; d3 = 0;
    end else begin
      d1 = 1; d2 = 0;
      d3 = mode.second ? (decision > thresh) : 1'b1;
    end
    if (extra_left > 0) tail_step(1'b1, d1);
    if (extra_left > 1) tail_step(1'b1, d2);
    if (extra_left > 2) tail_step(1'b0, d3);
  endfunction

  function automatic void load_line(input logic [CB-1:0] x0, y0, x1, y1,
                                    input logic [COLB-1:0] color);
    int dx, dy, mj, mn;
    dx = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
    dy = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
    line_color = color;
    mode = '0;
    mode.xneg = (x1 < x0);
    mode.yneg = (y1 < y0);
    if (dx > dy) begin
      mj = dx; mn = dy;
    end else begin
      mj = dy; mn = dx; mode.ymaj = 1'b1;
    end
    front_x = x0; front_y = y0; back_x = x1; back_y = y1;
    emit(1'b1);
    emit(1'b0);
    steps_left = (mj == 0) ? 0 : (mj - 1) >> 2;
    extra_left = (mj == 0) ? 0 : (mj - 1) & 3;
    inc_two = mn * 4 - mj * 2;
    if (inc_two < 0) begin
      thresh   = mn * 2;
      inc_one  = thresh * 2;
      decision = inc_one - mj;
    end else begin
      mode.second = 1'b1;
      thresh   = (mn - mj) * 2;
      inc_one  = thresh * 2;
      decision = inc_one + mj;
    end
    line_active = (steps_left != 0 || extra_left != 0);
  endfunction

  function automatic pixel_group_t rasterize_item(input logic cmd,
      input logic [CB-1:0] x0, y0, x1, y1, input logic [COLB-1:0] color);
    pixel_group_t g;
    bit ends;
    slot_n = 0;
    for (int i = 0; i < 4; i++) begin
      slot_x[i] = '0;
      slot_y[i] = '0;
    end
    ends = 1'b0;
    if (cmd == OP_START) begin
      load_line(x0, y0, x1, y1, color);
      ends = !line_active;
    end else if (!line_active) begin
      ends = 1'b1;
    end else if (steps_left != 0) begin
      double_step();
      steps_left--;
      if (steps_left == 0 && extra_left == 0) begin
        line_active = 1'b0;
        ends = 1'b1;
      end
    end else begin
      finish_middle();
      line_active = 1'b0;
      ends = 1'b1;
    end
    g.count = slot_n[2:0];
    g.xa = slot_x[0]; g.ya = slot_y[0];
    g.xb = slot_x[1]; g.yb = slot_y[1];
    g.xc = slot_x[2]; g.yc = slot_y[2];
    g.xd = slot_x[3]; g.yd = slot_y[3];
    g.color = (slot_n != 0) ? line_color : '0;
    g.last = ends;
    return g;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pixel_group_t want;
    if (rst) begin
      expected_groups.delete();
      front_x = '0; front_y = '0; back_x = '0; back_y = '0;
      decision = 0; thresh = 0; inc_one = 0; inc_two = 0;
      steps_left = 0; extra_left = 0; mode = '0; line_color = '0;
      line_active = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_groups.size() == 0) begin
          $error("pixel group came out with nothing expected");
          errors++;
        end else begin
          want = expected_groups.pop_front();
          check_field("pixel_count", want.count, pixel_count);
          check_field("xa", want.xa, xa);
          check_field("ya", want.ya, ya);
          check_field("xb", want.xb, xb);
          check_field("yb", want.yb, yb);
          check_field("xc", want.xc, xc);
          check_field("yc", want.yc, yc);
          check_field("xd", want.xd, xd);
          check_field("yd", want.yd, yd);
          check_field("pixel_color", want.color, pixel_color);
          check_field("last", want.last, last);
          groups++;
          pixels += want.count;
        end
      end
      if (in_valid && !in_stall)
        expected_groups.push_back(rasterize_item(op, x_start, y_start, x_end, y_end, pen_color));
    end
    fail_count     <= errors;
    pending_groups <= expected_groups.size();
    groups_checked <= groups;
    pixels_checked <= pixels;
  end

  initial begin
    errors = 0;
    groups = 0;
    pixels = 0;
  end

endmodule

### tb/tb_double_step_line_rasterizer.sv
// Testbench top for the double-step line rasterizer: clock, reset, stimulus, verdict.
// Depends on dslr_pkg, double_step_line_rasterizer and dslr_pixel_checker.
module tb_double_step_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import dslr_pkg::*;

  localparam int unsigned CB   = DSLR_COORD_BITS;
  localparam int unsigned COLB = DSLR_COLOR_BITS;
  localparam int          CMAX = (1 << CB) - 1;

  localparam int ITEM_TARGET = 650;
  localparam int QUIET_FROM  = 560;     // no idling on either side from here on
  localparam int CYCLE_LIMIT = 400000;  // far above the slowest legal run

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            op = OP_START;
  logic [CB-1:0]   x_start = '0;
  logic [CB-1:0]   y_start = '0;
  logic [CB-1:0]   x_end = '0;
  logic [CB-1:0]   y_end = '0;
  logic [COLB-1:0] pen_color = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [2:0]      pixel_count;
  logic [CB-1:0]   xa, ya, xb, yb, xc, yc, xd, yd;
  logic [COLB-1:0] pixel_color;
  logic            last;

  int unsigned fail_count, pending_groups, groups_checked, pixels_checked;

  bit          quiet = 1'b0;   // set for the tail of the run
  int          items_sent = 0;
  int          lines_started = 0;
  int          stall_run = 0;
  int unsigned cycle_count = 0;

  double_step_line_rasterizer #(
    .COORD_BITS (CB),
    .COLOR_BITS (COLB)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .pen_color   (pen_color),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_count (pixel_count),
    .xa          (xa),
    .ya          (ya),
    .xb          (xb),
    .yb          (yb),
    .xc          (xc),
    .yc          (yc),
    .xd          (xd),
    .yd          (yd),
    .pixel_color (pixel_color),
    .last        (last)
  );

  dslr_pixel_checker #(
    .CB   (CB),
    .COLB (COLB)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .x_start        (x_start),
    .y_start        (y_start),
    .x_end          (x_end),
    .y_end          (y_end),
    .pen_color      (pen_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_count    (pixel_count),
    .xa             (xa),
    .ya             (ya),
    .xb             (xb),
    .yb             (yb),
    .xc             (xc),
    .yc             (yc),
    .xd             (xd),
    .yd             (yd),
    .pixel_color    (pixel_color),
    .last           (last),
    .fail_count     (fail_count),
    .pending_groups (pending_groups),
    .groups_checked (groups_checked),
    .pixels_checked (pixels_checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure: random stall bursts, off during reset and in the
  // quiet tail. Driven on the falling edge like all inputs.
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_run = 0;
      out_stall = 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_run = $urandom_range(1, 16) - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Watchdog: a hung handshake or a lost pixel group ends up here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d pixel groups outstanding",
             cycle_count, pending_groups);
    $display("*** FAILED ***");
    $finish;
  end

  // Enter at a falling edge; leaves at the falling edge after the item is taken.
  // Valid stays high into the next call, so back-to-back items need no gap.
  task automatic send_item(input logic cmd, input logic [CB-1:0] x0, y0, x1, y1,
                           input logic [COLB-1:0] color);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid  = 1'b1;
    op        = cmd;
    x_start   = x0;
    y_start   = y0;
    x_end     = x1;
    y_end     = y1;
    pen_color = color;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (cmd == OP_START) lines_started++;
  endtask

  // Endpoint fields are don't-care on an advance; fill them with noise.
  task automatic send_advance();
    send_item(OP_ADVANCE, CB'($urandom_range(0, CMAX)), CB'($urandom_range(0, CMAX)),
              CB'($urandom_range(0, CMAX)), CB'($urandom_range(0, CMAX)),
              COLB'($urandom));
  endtask

  task automatic draw_line(input logic [CB-1:0] x0, y0, x1, y1,
                           input logic [COLB-1:0] color, input int advances);
    send_item(OP_START, x0, y0, x1, y1, color);
    repeat (advances) send_advance();
  endtask

  // Advances that bring a line to its last group: one per double step plus
  // one for any leftover middle pixels.
  function automatic int line_groups(input logic [CB-1:0] x0, y0, x1, y1);
    int dx, dy, mj;
    dx = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
    dy = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
    mj = (dx > dy) ? dx : dy;
    if (mj <= 1) return 0;
    return ((mj - 1) >> 2) + ((((mj - 1) & 3) != 0) ? 1 : 0);
  endfunction

  // Random line with spans up to 'span'; sometimes a 45 degree line, and
  // sometimes pushed against the edges of the coordinate space.
  task automatic pick_line(input int span, output logic [CB-1:0] x0, y0, x1, y1);
    int dx, dy, bx, by;
    dx = $urandom_range(0, span);
    dy = ($urandom_range(0, 7) == 0) ? dx : $urandom_range(0, span);
    bx = $urandom_range(0, CMAX - dx);
    by = $urandom_range(0, CMAX - dy);
    if ($urandom_range(0, 7) == 0) bx = $urandom_range(0, 1) ? 0 : CMAX - dx;
    if ($urandom_range(0, 7) == 0) by = $urandom_range(0, 1) ? 0 : CMAX - dy;
    if ($urandom_range(0, 1)) begin
      x0 = CB'(bx); x1 = CB'(bx + dx);
    end else begin
      x0 = CB'(bx + dx); x1 = CB'(bx);
    end
    if ($urandom_range(0, 1)) begin
      y0 = CB'(by); y1 = CB'(by + dy);
    end else begin
      y0 = CB'(by + dy); y1 = CB'(by);
    end
  endtask

  initial begin
    logic [CB-1:0] x0, y0, x1, y1;
    int pick;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    send_advance();                                  // nothing drawn yet: empty group
    draw_line(5, 5, 5, 5, '0, 0);                    // zero length: endpoints only
    send_advance();                                  // line already closed
    draw_line(0, 0, 1, 0, {COLB{1'b1}}, 0);          // major span of one
    draw_line(CMAX, CMAX, CMAX - 1, CMAX - 1, 24'h5A5A5A, 0);
    // first branch, x major, one double step, no middle pixels
    draw_line(10, 10, 15, 12, 24'h123456, line_groups(10, 10, 15, 12));
    // second branch, x stepping down, two middle pixels
    draw_line(100, 200, 93, 205, 24'hA5A5A5, line_groups(100, 200, 93, 205));
    // y major stepping down, boundary case 4*minor == 2*major
    draw_line(300, 50, 303, 44, 24'h0F0F0F, line_groups(300, 50, 303, 44));
    // equal spans: y taken as major, three middle pixels only
    draw_line(7, 7, 11, 11, 24'hF0F0F0, line_groups(7, 7, 11, 11));
    draw_line(0, CMAX, 2, CMAX, 24'h000001, line_groups(0, CMAX, 2, CMAX));
    // full-span lines, each dropped mid-way by the next start
    draw_line(0, CMAX, CMAX, 0, {COLB{1'b1}}, 3);
    draw_line(CMAX, 0, 0, CMAX, '0, 2);
    draw_line(CMAX, 0, 0, 3, 24'h800000, 1);
    draw_line(20, 40, 11, 38, 24'h7FFFFF, line_groups(20, 40, 11, 38));

    // ---- random part ----
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) quiet = 1'b1;
      pick = $urandom_range(0, 31);
      if (pick == 0) begin
        send_advance();                              // stray advance, may hit idle
      end else if (pick <= 2) begin
        pick_line(CMAX, x0, y0, x1, y1);             // long line, cut short
        draw_line(x0, y0, x1, y1, COLB'($urandom), $urandom_range(0, 12));
      end else if (pick <= 4) begin
        pick_line(24, x0, y0, x1, y1);               // broken-off short line
        draw_line(x0, y0, x1, y1, COLB'($urandom),
                  $urandom_range(0, line_groups(x0, y0, x1, y1)));
      end else if (pick <= 6) begin
        pick_line(300, x0, y0, x1, y1);
        draw_line(x0, y0, x1, y1, COLB'($urandom), line_groups(x0, y0, x1, y1));
      end else begin
        pick_line(24, x0, y0, x1, y1);
        draw_line(x0, y0, x1, y1, COLB'($urandom), line_groups(x0, y0, x1, y1));
      end
    end
    in_valid = 1'b0;

    // drain, then wait for anything unexpected to surface
    while (pending_groups != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d items over %0d line starts in %0d cycles.",
             items_sent, lines_started, cycle_count);
    $display("Compared %0d pixel groups carrying %0d pixels; %0d field errors.",
             groups_checked, pixels_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dslr_pkg.sv
rtl/dslr_setup.sv
rtl/dslr_advance.sv
rtl/double_step_line_rasterizer.sv
rtl/dslr_checker.sv
tb/dslr_pixel_checker.sv
tb/tb_double_step_line_rasterizer.sv
